// ===== rtl/core/first_fit_heap_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_macros
// Assertion macros shared by the heap allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// condition implies consequence in the same cycle
`define FFHA_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define FFHA_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Types and constants shared by the heap allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ffha_pkg;

  localparam int GRAN_SHIFT = 4;
  localparam int MIN_REST   = 2;
  localparam int NEED_W     = 33;
  localparam int OFFSET_W   = 18;
  localparam int FREE_W     = 19;
  localparam int GRAN_IN_W  = 15;

  // datapath command codes
  localparam logic [3:0] CMD_NOP    = 4'd0;
  localparam logic [3:0] CMD_INIT   = 4'd1;
  localparam logic [3:0] CMD_LOAD   = 4'd2;
  localparam logic [3:0] CMD_START  = 4'd3;
  localparam logic [3:0] CMD_A_RD   = 4'd4;
  localparam logic [3:0] CMD_A_CHK  = 4'd5;
  localparam logic [3:0] CMD_A_SPL  = 4'd6;
  localparam logic [3:0] CMD_F_SZ   = 4'd7;
  localparam logic [3:0] CMD_F_WALK = 4'd8;
  localparam logic [3:0] CMD_F_STEP = 4'd9;
  localparam logic [3:0] CMD_F_LNKB = 4'd10;
  localparam logic [3:0] CMD_F_LNKP = 4'd11;
  localparam logic [3:0] CMD_F_MN   = 4'd12;
  localparam logic [3:0] CMD_F_MP   = 4'd13;
  localparam logic [3:0] CMD_DONE   = 4'd14;

  typedef struct packed {
    logic [3:0] op;
  } cmd_t;

  typedef struct packed {
    logic op_free;
    logic a_early;
    logic a_walk_end;
    logic a_fit;
    logic a_split;
    logic a_rest_bad;
    logic f_early;
    logic f_bad_size;
    logic f_walk_more;
    logic f_reject;
    logic f_merge_next;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/core/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Sequencer for allocate and free requests; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ffha_pkg::status_t status,
  output ffha_pkg::cmd_t    cmd
);
  import ffha_pkg::*;

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_START  = 4'd2;
  localparam logic [3:0] ST_A_RD   = 4'd3;
  localparam logic [3:0] ST_A_CHK  = 4'd4;
  localparam logic [3:0] ST_A_SPL  = 4'd5;
  localparam logic [3:0] ST_F_SZ   = 4'd6;
  localparam logic [3:0] ST_F_WALK = 4'd7;
  localparam logic [3:0] ST_F_STEP = 4'd8;
  localparam logic [3:0] ST_F_LNKB = 4'd9;
  localparam logic [3:0] ST_F_LNKP = 4'd10;
  localparam logic [3:0] ST_F_MN   = 4'd11;
  localparam logic [3:0] ST_F_MP   = 4'd12;
  localparam logic [3:0] ST_DONE   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = CMD_NOP;
    case (state)
      ST_INIT: begin
        cmd.op     = CMD_INIT;
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.op = CMD_START;
        if (status.op_free) begin
          state_next = status.f_early ? ST_DONE : ST_F_SZ;
        end else begin
          state_next = status.a_early ? ST_DONE : ST_A_RD;
        end
      end
      ST_A_RD: begin
        cmd.op     = CMD_A_RD;
        state_next = status.a_walk_end ? ST_DONE : ST_A_CHK;
      end
      ST_A_CHK: begin
        cmd.op = CMD_A_CHK;
        if (!status.a_fit) begin
          state_next = ST_A_RD;
        end else if (status.a_split) begin
          state_next = status.a_rest_bad ? ST_DONE : ST_A_SPL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_A_SPL: begin
        cmd.op     = CMD_A_SPL;
        state_next = ST_DONE;
      end
      ST_F_SZ: begin
        cmd.op     = CMD_F_SZ;
        state_next = status.f_bad_size ? ST_DONE : ST_F_WALK;
      end
      ST_F_WALK: begin
        cmd.op = CMD_F_WALK;
        if (status.f_walk_more) begin
          state_next = ST_F_STEP;
        end else if (status.f_reject) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_F_LNKB;
        end
      end
      ST_F_STEP: begin
        cmd.op     = CMD_F_STEP;
        state_next = ST_F_WALK;
      end
      ST_F_LNKB: begin
        cmd.op     = CMD_F_LNKB;
        state_next = ST_F_LNKP;
      end
      ST_F_LNKP: begin
        cmd.op     = CMD_F_LNKP;
        state_next = status.f_merge_next ? ST_F_MN : ST_F_MP;
      end
      ST_F_MN: begin
        cmd.op     = CMD_F_MN;
        state_next = ST_F_MP;
      end
      ST_F_MP: begin
        cmd.op     = CMD_F_MP;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        cmd.op = CMD_DONE;
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ffha_datapath.sv =====
// ----------------------------------------------------------------------------
// ffha_datapath
// Block header memories, list walk registers, free byte count and result
// register of the heap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

module ffha_datapath #(
  parameter int HEAP_GRANULES = 16384
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ffha_pkg::cmd_t                  cmd,
  output ffha_pkg::status_t               status,
  input  logic                            operation,
  input  logic [31:0]                     request_bytes,
  input  logic [ffha_pkg::OFFSET_W-1:0]   block_address,
  input  logic                            heap_enabled_we,
  input  logic                            heap_enabled,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [ffha_pkg::OFFSET_W-1:0]   payload_offset,
  output logic                            alloc_ok,
  output logic [ffha_pkg::FREE_W-1:0]     free_bytes
);
  import ffha_pkg::*;

  localparam int GW = $clog2(HEAP_GRANULES + 1);
  localparam int AW = $clog2(HEAP_GRANULES);
  localparam int SW = GW + 1;
  localparam int FW = $clog2(HEAP_GRANULES * 16 + 1);
  localparam int TW = GW + GRAN_SHIFT;
  localparam logic [GW-1:0] NO_LINK    = GW'(HEAP_GRANULES);
  localparam logic [FW-1:0] HEAP_BYTES = FW'(HEAP_GRANULES * 16);

  // header memories
  logic [GW-1:0] size_mem [HEAP_GRANULES];
  logic [GW-1:0] link_mem [HEAP_GRANULES];

  // control registers
  logic          en;
  logic [GW-1:0] head;
  logic [FW-1:0] fbc;

  // request and walk registers
  logic                op_q;
  logic [31:0]         bytes_q;
  logic [OFFSET_W-1:0] addr_q;
  logic [GW-1:0]       prev;
  logic [GW-1:0]       cur;
  logic [GW-1:0]       prev_sz;
  logic [GW-1:0]       steps;
  logic [GW-1:0]       b;
  logic [GW-1:0]       sz;
  logic [GW-1:0]       bsz;
  logic [GW-1:0]       blink;
  logic [GW-1:0]       rest_q;
  logic [GW-1:0]       rd_sz;
  logic [GW-1:0]       rd_link;
  logic [OFFSET_W-1:0] res_payload;
  logic                res_ok;

  // memory port controls
  logic          rd_en;
  logic [GW-1:0] rd_addr;
  logic          sz_we;
  logic [GW-1:0] sz_waddr;
  logic [GW-1:0] sz_wdata;
  logic          ln_we;
  logic [GW-1:0] ln_waddr;
  logic [GW-1:0] ln_wdata;

  // derived values
  logic [NEED_W-1:0]    need_c;
  logic [NEED_W-1:0]    rest_sum;
  logic [GRAN_IN_W-1:0] g_c;
  logic [GRAN_IN_W-1:0] b_wide;
  logic [GW-1:0]        b_c;
  logic [SW-1:0]        b_end;
  logic [SW-1:0]        prev_end;
  logic [GW-1:0]        cur_lnk;
  logic                 merge_prev;
  logic [GW-1:0]        tk_gran;
  logic [TW-1:0]        taken;
  logic [FW-1:0]        fbc_sub;
  logic [FW:0]          fbc_sum;
  logic [FW-1:0]        fbc_add;
  logic [OFFSET_W-1:0]  pay_c;

  assign need_c   = ((NEED_W'(bytes_q) + NEED_W'(15)) >> GRAN_SHIFT) + NEED_W'(1);
  assign rest_sum = NEED_W'(cur) + need_c;
  assign g_c      = GRAN_IN_W'(addr_q >> GRAN_SHIFT);
  assign b_wide   = g_c - GRAN_IN_W'(1);
  assign b_c      = GW'(b_wide);
  assign b_end    = SW'(b) + SW'(sz);
  assign prev_end = SW'(prev) + SW'(prev_sz);
  assign cur_lnk  = (cur < NO_LINK) ? cur : NO_LINK;
  assign merge_prev = (prev != NO_LINK) && (prev_end == SW'(b));
  assign pay_c    = (OFFSET_W'(cur) + OFFSET_W'(1)) << GRAN_SHIFT;

  // byte count update, saturating both ways
  always_comb begin
    case (cmd.op)
      CMD_A_SPL:  tk_gran = GW'(need_c);
      CMD_F_LNKB: tk_gran = sz;
      default:    tk_gran = rd_sz;
    endcase
  end
  assign taken   = TW'(tk_gran) << GRAN_SHIFT;
  assign fbc_sub = (FW'(taken) > fbc) ? '0 : fbc - FW'(taken);
  assign fbc_sum = (FW + 1)'(fbc) + (FW + 1)'(taken);
  assign fbc_add = (fbc_sum > (FW + 1)'(HEAP_BYTES)) ? HEAP_BYTES : FW'(fbc_sum);

  // status to the controller
  always_comb begin
    status.op_free      = op_q;
    status.a_early      = !en || (bytes_q == 32'd0);
    status.a_walk_end   = (cur >= NO_LINK) || (steps >= NO_LINK);
    status.a_fit        = NEED_W'(rd_sz) >= need_c;
    status.a_split      = NEED_W'(rd_sz) >= need_c + NEED_W'(MIN_REST);
    status.a_rest_bad   = rest_sum >= NEED_W'(HEAP_GRANULES);
    status.f_early      = !en || (g_c == '0) ||
                          (32'(b_wide) >= 32'(HEAP_GRANULES));
    status.f_bad_size   = (rd_sz == '0) || (SW'(rd_sz) > SW'(NO_LINK) - SW'(b));
    status.f_walk_more  = (cur < NO_LINK) && (cur < b) && (steps < NO_LINK);
    status.f_reject     = (cur == b) || ((cur < NO_LINK) && (b_end > SW'(cur))) ||
                          ((prev != NO_LINK) && (prev_end > SW'(b)));
    status.f_merge_next = (cur < NO_LINK) && (b_end == SW'(cur));
    status.out_free     = !out_valid || out_ready;
  end

  // memory port selection
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = cur;
    sz_we    = 1'b0;
    sz_waddr = cur;
    sz_wdata = GW'(need_c);
    ln_we    = 1'b0;
    ln_waddr = prev;
    ln_wdata = rd_link;
    case (cmd.op)
      CMD_INIT: begin
        sz_we    = 1'b1;
        sz_waddr = '0;
        sz_wdata = NO_LINK;
        ln_we    = 1'b1;
        ln_waddr = '0;
        ln_wdata = NO_LINK;
      end
      CMD_START: begin
        rd_en   = 1'b1;
        rd_addr = b_c;
      end
      CMD_A_RD, CMD_F_WALK, CMD_F_LNKB: begin
        rd_en = 1'b1;
        if (cmd.op == CMD_F_LNKB) begin
          ln_we    = 1'b1;
          ln_waddr = b;
          ln_wdata = cur_lnk;
        end
      end
      CMD_A_CHK: begin
        if (status.a_fit && status.a_split && !status.a_rest_bad) begin
          sz_we    = 1'b1;
          sz_waddr = GW'(rest_sum);
          sz_wdata = rd_sz - GW'(need_c);
          ln_we    = 1'b1;
          ln_waddr = GW'(rest_sum);
          ln_wdata = rd_link;
        end else if (status.a_fit && !status.a_split && (prev != NO_LINK)) begin
          ln_we = 1'b1;
        end
      end
      CMD_A_SPL: begin
        sz_we    = 1'b1;
        ln_we    = (prev != NO_LINK);
        ln_wdata = rest_q;
      end
      CMD_F_LNKP: begin
        ln_we    = (prev != NO_LINK);
        ln_wdata = b;
      end
      CMD_F_MN: begin
        sz_we    = 1'b1;
        sz_waddr = b;
        sz_wdata = sz + rd_sz;
        ln_we    = 1'b1;
        ln_waddr = b;
      end
      CMD_F_MP: begin
        sz_we    = merge_prev;
        sz_waddr = prev;
        sz_wdata = prev_sz + bsz;
        ln_we    = merge_prev;
        ln_wdata = blink;
      end
      default: begin
      end
    endcase
  end

  // header memories, registered read
  always_ff @(posedge clk) begin
    if (sz_we) begin
      size_mem[sz_waddr[AW-1:0]] <= sz_wdata;
    end
    if (ln_we) begin
      link_mem[ln_waddr[AW-1:0]] <= ln_wdata;
    end
    if (rd_en) begin
      rd_sz   <= size_mem[rd_addr[AW-1:0]];
      rd_link <= link_mem[rd_addr[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      en        <= 1'b1;
      head      <= '0;
      fbc       <= HEAP_BYTES;
      out_valid <= 1'b0;
    end else begin
      if (heap_enabled_we) begin
        en <= heap_enabled;
      end
      // result register fills on done, empties when taken
      if ((cmd.op == CMD_DONE) && status.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        CMD_A_CHK: begin
          if (status.a_fit && !status.a_split) begin
            if (prev == NO_LINK) begin
              head <= rd_link;
            end
            fbc <= fbc_sub;
          end
        end
        CMD_A_SPL: begin
          if (prev == NO_LINK) begin
            head <= rest_q;
          end
          fbc <= fbc_sub;
        end
        CMD_F_LNKB: begin
          if (prev == NO_LINK) begin
            head <= b;
          end
          fbc <= fbc_add;
        end
        default: begin
        end
      endcase
    end
  end

  // request, walk and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        op_q    <= operation;
        bytes_q <= request_bytes;
        addr_q  <= block_address;
      end
      CMD_START: begin
        prev        <= NO_LINK;
        cur         <= head;
        steps       <= '0;
        b           <= b_c;
        res_payload <= '0;
        res_ok      <= 1'b0;
      end
      CMD_A_CHK: begin
        if (!status.a_fit) begin
          prev  <= cur;
          cur   <= rd_link;
          steps <= steps + GW'(1);
        end else if (status.a_split) begin
          rest_q <= GW'(rest_sum);
        end else begin
          res_payload <= pay_c;
          res_ok      <= 1'b1;
        end
      end
      CMD_A_SPL: begin
        res_payload <= pay_c;
        res_ok      <= 1'b1;
      end
      CMD_F_SZ: begin
        sz <= rd_sz;
      end
      CMD_F_STEP: begin
        prev    <= cur;
        prev_sz <= rd_sz;
        cur     <= rd_link;
        steps   <= steps + GW'(1);
      end
      CMD_F_LNKB: begin
        bsz   <= sz;
        blink <= cur_lnk;
      end
      CMD_F_MN: begin
        bsz   <= sz + rd_sz;
        blink <= rd_link;
      end
      CMD_DONE: begin
        if (status.out_free) begin
          payload_offset <= res_payload;
          alloc_ok       <= res_ok;
          free_bytes     <= FREE_W'(fbc);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/first_fit_heap_allocator.sv =====
// Sequence after acceptance: a request that fails early goes from START straight
// to DONE; an allocate reads and checks each free block visited and splits the
// fitting block if needed; a free reads the size, walks the free blocks below it,
// links the block in and may merge with its neighbours. The next request is taken
// while the previous result waits in the output register.
// Reset: synchronous; the INIT state after reset writes the initial heap header.
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over 16-byte granules with an address-ordered free list
// and coalescing on free.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"

module first_fit_heap_allocator #(
  parameter int HEAP_GRANULES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [31:0] request_bytes,
  input  logic [17:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [17:0] payload_offset,
  output logic        alloc_ok,
  output logic [18:0] free_bytes,
  input  logic        heap_enabled_we,
  input  logic        heap_enabled
);
  import ffha_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer
  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // header memories and arithmetic
  ffha_datapath #(
    .HEAP_GRANULES (HEAP_GRANULES)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .operation       (operation),
    .request_bytes   (request_bytes),
    .block_address   (block_address),
    .heap_enabled_we (heap_enabled_we),
    .heap_enabled    (heap_enabled),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .payload_offset  (payload_offset),
    .alloc_ok        (alloc_ok),
    .free_bytes      (free_bytes)
  );

  // checks
  `FFHA_ASSERT_NEXT(a_accept_starts, in_valid && in_ready, cmd.op == CMD_START, "request not started")
  `FFHA_ASSERT_NOW(a_ok_has_offset, out_valid && alloc_ok, payload_offset != 18'd0, "ok without offset")
  `FFHA_ASSERT_NOW(a_free_bound, out_valid, 32'(free_bytes) <= 32'(HEAP_GRANULES * 16), "free bytes overflow")

endmodule

`default_nettype wire
